// ===== src/kdse_pkg.sv =====
`default_nettype none
package kdse_pkg;

    localparam int unsigned NUM_DIGITS = 4;
    localparam int unsigned POS_W      = $clog2(NUM_DIGITS);
    localparam int unsigned COUNT_W    = 3;
    localparam int unsigned HOLD_W     = 16;
    localparam int unsigned SEG_W      = 8;
    localparam int unsigned CODE_W     = 4;
    localparam int unsigned ROW_W      = 4;

    localparam logic [HOLD_W-1:0]  HOLDOFF_RESET = 16'd100;
    localparam logic [CODE_W-1:0]  KEY_CLEAR     = 4'hA;
    localparam logic [CODE_W-1:0]  KEY_LAST_DIG  = 4'h9;
    localparam logic [COUNT_W-1:0] COUNT_FULL    = 3'd4;

    // Decoded keypad key
    typedef struct packed {
        logic              seen;
        logic [CODE_W-1:0] code;
    } t_key;

    // One scan tick's result
    typedef struct packed {
        logic [ROW_W-1:0]  digit_enable_n;
        logic [SEG_W-1:0]  segment_byte;
        logic              key_seen;
        logic [CODE_W-1:0] key_code;
        logic              key_accepted;
        logic              beep_start;
    } t_result;

    // Segment pattern for digits 0..9
    function automatic logic [SEG_W-1:0] seg_of(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] s;
        case (code)
            4'd0:    s = 8'h5f;
            4'd1:    s = 8'h41;
            4'd2:    s = 8'h9b;
            4'd3:    s = 8'hd3;
            4'd4:    s = 8'hc5;
            4'd5:    s = 8'hd6;
            4'd6:    s = 8'hde;
            4'd7:    s = 8'h43;
            4'd8:    s = 8'hdf;
            4'd9:    s = 8'hd7;
            default: s = '0;
        endcase
        return s;
    endfunction

    // Key code by column (scan position) and row index
    function automatic logic [CODE_W-1:0] key_of(input logic [POS_W-1:0] col,
                                                 input logic [1:0] row);
        logic [CODE_W-1:0] k;
        case ({col, row})
            4'b00_00: k = 4'h1;
            4'b00_01: k = 4'h4;
            4'b00_10: k = 4'h7;
            4'b00_11: k = 4'he;
            4'b01_00: k = 4'h2;
            4'b01_01: k = 4'h5;
            4'b01_10: k = 4'h8;
            4'b01_11: k = 4'h0;
            4'b10_00: k = 4'h3;
            4'b10_01: k = 4'h6;
            4'b10_10: k = 4'h9;
            4'b10_11: k = 4'hf;
            4'b11_00: k = 4'ha;
            4'b11_01: k = 4'hb;
            4'b11_10: k = 4'hc;
            4'b11_11: k = 4'hd;
            default:  k = '0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== src/kdse_key_decode.sv =====
`default_nettype none
module kdse_key_decode (
    input  wire logic [kdse_pkg::POS_W-1:0] i_col,
    input  wire logic [kdse_pkg::ROW_W-1:0] i_rows,
    output kdse_pkg::t_key                  o_key
);
    import kdse_pkg::*;

    logic [1:0] row_idx;
    logic       any_low;

    // Highest numbered low row wins
    always_comb begin
        row_idx = '0;
        any_low = 1'b0;
        for (int i = 0; i < ROW_W; i++) begin
            if (!i_rows[i]) begin
                row_idx = 2'(i);
                any_low = 1'b1;
            end
        end
        o_key.seen = any_low;
        o_key.code = any_low ? key_of(i_col, row_idx) : '0;
    end

endmodule
`default_nettype wire

// ===== src/kdse_entry_ctrl.sv =====
`default_nettype none
module kdse_entry_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [kdse_pkg::ROW_W-1:0]  i_rows,
    input  wire logic [kdse_pkg::HOLD_W-1:0] i_holdoff_ticks,
    output kdse_pkg::t_result                o_res
);
    import kdse_pkg::*;

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [SEG_W-1:0]   r_digit [NUM_DIGITS];
    logic [SEG_W-1:0]   n_digit [NUM_DIGITS];
    logic [COUNT_W-1:0] r_count, n_count;
    logic [HOLD_W-1:0]  r_hold, n_hold;
    t_key               w_key;
    logic               accepted;

    kdse_key_decode u_key_decode (
        .i_col  (r_pos),
        .i_rows (i_rows),
        .o_key  (w_key)
    );

    always_comb begin
        n_pos    = r_pos + 1'b1;
        n_count  = r_count;
        n_hold   = r_hold;
        accepted = 1'b0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            n_digit[i] = r_digit[i];
        end
        if (r_hold != '0) begin
            n_hold = r_hold - 1'b1;
        end else if (w_key.seen) begin
            if (w_key.code == KEY_CLEAR) begin
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    n_digit[i] = '0;
                end
                n_count  = '0;
                accepted = 1'b1;
            end else if (w_key.code <= KEY_LAST_DIG && r_count < COUNT_FULL) begin
                // shift left, enter at the rightmost digit
                for (int i = 0; i < NUM_DIGITS - 1; i++) begin
                    n_digit[i] = r_digit[i+1];
                end
                n_digit[NUM_DIGITS-1] = seg_of(w_key.code);
                n_count  = r_count + 1'b1;
                accepted = 1'b1;
            end
            if (accepted) begin
                n_hold = i_holdoff_ticks;
            end
        end

        o_res.digit_enable_n = ~(ROW_W'(1) << r_pos);
        o_res.segment_byte   = r_digit[r_pos];
        o_res.key_seen       = w_key.seen;
        o_res.key_code       = w_key.code;
        o_res.key_accepted   = accepted;
        o_res.beep_start     = accepted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_hold  <= '0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_digit[i] <= '0;
            end
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_count <= n_count;
            r_hold  <= n_hold;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_digit[i] <= n_digit[i];
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/keypad_display_scan_entry.sv =====
`default_nettype none
// Four-digit multiplexed display and 4x4 keypad scanner. Every request on
// the slave stream is one scan tick carrying the active-low keypad rows; the
// block steps the scanned digit 1..4 (wrapping), and returns one result with
// that digit's active-low enable, its stored segment byte (as it was before
// this tick), the decoded key of the matching column, and whether the key
// was taken. Key A blanks the display; keys 0..9 enter at the rightmost
// digit while fewer than four are shown; an accepted key raises beep_start
// and starts a hold-off of holdoff_ticks scan ticks. Throughput is one tick
// per clock: all decode and state update sits between the scan state
// registers and a single output register, and a new request is taken
// whenever that register is empty or is being drained in the same cycle.
// The result is registered and valid in the cycle after its request is taken.
// holdoff_ticks resets to 100 and should only be written while no tick is outstanding.
module keypad_display_scan_entry (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // hold-off configuration write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    // scan tick requests
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [3:0] row_lines, [7:4] zero
    // scan results
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata    // [3:0] digit_enable_n, [11:4] segment_byte,
                                          // [12] key_seen, [16:13] key_code,
                                          // [17] key_accepted, [18] beep_start,
                                          // [23:19] zero
);
    import kdse_pkg::*;

    logic [HOLD_W-1:0] r_holdoff_ticks;
    logic              r_out_valid;
    t_result           r_out;
    t_result           w_res;
    logic              s_acc;

    // Config register: always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff_ticks <= HOLDOFF_RESET;
        end else if (i_cfg_valid) begin
            r_holdoff_ticks <= i_cfg_data;
        end
    end

    // Take a new request when the output register is free or draining
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_acc      = i_s_tvalid && o_s_tready;

    kdse_entry_ctrl u_entry_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (s_acc),
        .i_rows          (i_s_tdata[ROW_W-1:0]),
        .i_holdoff_ticks (r_holdoff_ticks),
        .o_res           (w_res)
    );

    // Output register: hold while stalled, load on each request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0,
                         r_out.beep_start,
                         r_out.key_accepted,
                         r_out.key_code,
                         r_out.key_seen,
                         r_out.segment_byte,
                         r_out.digit_enable_n};

`ifndef SYNTHESIS
    // A taken key always comes from a detected key
    a_accept_needs_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && w_res.key_accepted |-> w_res.key_seen)
        else $error("key accepted without a key seen");

    // Exactly one digit enabled on every result
    a_one_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot(~r_out.digit_enable_n))
        else $error("digit enable not one-hot low");

    // A nonzero hold-off blocks a key on the very next tick
    a_holdoff_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && w_res.key_accepted && r_holdoff_ticks != '0
        |=> !(s_acc && w_res.key_accepted))
        else $error("key accepted during hold-off");

    // A result under back-pressure is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |-> !s_acc)
        else $error("stalled result overwritten");
`endif

endmodule
`default_nettype wire

// ===== tb/keypad_display_scan_entry_check.sv =====
`default_nettype none
// Watches the three channels, keeps a cycle-free model of the scanner and
// compares every result request with the oldest prediction.
module keypad_display_scan_entry_check (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [3:0] row_lines, [7:4] zero
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [23:0] i_m_tdata,   // [3:0] digit_enable_n, [11:4] segment_byte,
                                          // [12] key_seen, [16:13] key_code,
                                          // [17] key_accepted, [18] beep_start,
                                          // [23:19] zero
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_accepted
);
    timeunit 1ns;
    timeprecision 1ps;
    import kdse_pkg::*;

    // Result word, highest field first so that enable_n lands in bits [3:0]
    typedef struct packed {
        logic [4:0]        pad;
        logic              beep;
        logic              taken;
        logic [CODE_W-1:0] code;
        logic              seen;
        logic [SEG_W-1:0]  seg;
        logic [3:0]        enable_n;
    } t_scan_word;

    // Digit 0..9 to segment pattern, digit 0 in the lowest byte
    localparam logic [9:0][SEG_W-1:0] SEG_LUT = {
        8'hd7, 8'hdf, 8'h43, 8'hde, 8'hd6, 8'hc5, 8'hd3, 8'h9b, 8'h41, 8'h5f
    };
    // Key code indexed by {column, row}
    localparam logic [15:0][CODE_W-1:0] KEY_LUT = {
        4'hd, 4'hc, 4'hb, 4'ha,
        4'hf, 4'h9, 4'h6, 4'h3,
        4'h0, 4'h8, 4'h5, 4'h2,
        4'he, 4'h7, 4'h4, 4'h1
    };

    logic [2:0]         scan_pos;
    logic [SEG_W-1:0]   digit_q [NUM_DIGITS];
    logic [COUNT_W-1:0] n_shown;
    logic [HOLD_W-1:0]  hold_left;
    logic [HOLD_W-1:0]  hold_ticks;
    t_scan_word         scan_words_q [$];
    int                 n_fail;
    int                 n_checked;
    int                 n_taken;

    task automatic scan_tick(input logic [3:0] rows);
        logic [1:0]        col;
        logic [2:0]        top_row;
        logic [CODE_W-1:0] code;
        logic              taken;
        t_scan_word        w;
        scan_pos = (scan_pos >= 3'd4) ? 3'd1 : scan_pos + 3'd1;
        col      = 2'(scan_pos - 3'd1);
        w        = '0;
        w.enable_n = ~(4'b0001 << col);
        w.seg      = digit_q[col];
        top_row = '0;
        for (int i = 0; i < 4; i++) begin
            if (!rows[i]) top_row = 3'(i + 1);
        end
        code  = '0;
        taken = 1'b0;
        if (top_row != 0) code = KEY_LUT[{col, 2'(top_row - 3'd1)}];
        if (hold_left != 0) begin
            hold_left = hold_left - 1'b1;
        end else if (top_row != 0) begin
            if (code == KEY_CLEAR) begin
                for (int d = 0; d < NUM_DIGITS; d++) digit_q[d] = '0;
                n_shown = '0;
                taken   = 1'b1;
            end else if (code <= KEY_LAST_DIG && n_shown < COUNT_FULL) begin
                digit_q[0] = digit_q[1];
                digit_q[1] = digit_q[2];
                digit_q[2] = digit_q[3];
                digit_q[3] = SEG_LUT[code];
                n_shown    = n_shown + 1'b1;
                taken      = 1'b1;
            end
            if (taken) hold_left = hold_ticks;
        end
        w.seen  = (top_row != 0);
        w.code  = code;
        w.taken = taken;
        w.beep  = taken;
        if (taken) n_taken++;
        scan_words_q.push_back(w);
    endtask

    task automatic check_word(input t_scan_word got);
        t_scan_word want;
        n_checked++;
        if (scan_words_q.size() == 0) begin
            n_fail++;
            if (n_fail <= 10)
                $display("%0t: unexpected result %h with nothing outstanding", $realtime, got);
        end else begin
            want = scan_words_q.pop_front();
            if (got.enable_n != want.enable_n || got.seg != want.seg ||
                got.seen != want.seen || got.code != want.code ||
                got.taken != want.taken || got.beep != want.beep || got.pad != want.pad) begin
                n_fail++;
                if (n_fail <= 10) begin
                    $display("%0t: result mismatch en_n %h/%h seg %h/%h seen %b/%b (exp/act)",
                             $realtime, want.enable_n, got.enable_n, want.seg, got.seg,
                             want.seen, got.seen);
                    $display("    code %h/%h taken %b/%b beep %b/%b pad %h/%h (exp/act)",
                             want.code, got.code, want.taken, got.taken,
                             want.beep, got.beep, want.pad, got.pad);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scan_pos   = '0;
            for (int d = 0; d < NUM_DIGITS; d++) digit_q[d] = '0;
            n_shown    = '0;
            hold_left  = '0;
            hold_ticks = HOLDOFF_RESET;
            scan_words_q.delete();
        end else begin
            // drain first: a result can never belong to a tick taken at this edge
            if (i_m_tvalid && i_m_tready) check_word(t_scan_word'(i_m_tdata));
            if (i_s_tvalid && i_s_tready) scan_tick(i_s_tdata[3:0]);
            if (i_cfg_valid && i_cfg_ready) hold_ticks = i_cfg_data;
        end
        o_pending    <= scan_words_q.size();
        o_fail_count <= n_fail;
        o_checked    <= n_checked;
        o_accepted   <= n_taken;
    end

endmodule
`default_nettype wire

// ===== tb/keypad_display_scan_entry_test.sv =====
`default_nettype none
module keypad_display_scan_entry_test;
    timeunit 1ns;
    timeprecision 1ps;
    import kdse_pkg::*;

    localparam logic [3:0] ROWS_NONE          = 4'hF;  // no row pulled low
    localparam int         CLEAR_COL          = 3;     // column that carries key A
    localparam int         RANDOM_PHASE_TICKS = 190;
    localparam int         LAST_PHASE_TICKS   = 60;

    // Directed ticks, starting on digit one: back-to-back entries with zero
    // hold-off, several rows at once, every key 0..F, a full display, clears.
    localparam logic [0:19][3:0] DIRECTED_ROWS = {
        4'b1110, 4'b0000, 4'b1101, 4'b1011,
        4'b0111, 4'b1011, 4'b1011, 4'b1110,
        4'b1111, 4'b1110, 4'b0111, 4'b1101,
        4'b1101, 4'b1101, 4'b1110, 4'b0111,
        4'b1011, 4'b0110, 4'b1110, 4'b1110
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic [7:0]  s_tdata;
    logic        m_tready;
    wire logic   cfg_ready;
    wire logic   s_tready;
    wire logic   m_tvalid;
    wire logic [23:0] m_tdata;

    int fail_count;
    int pending;
    int checked;
    int taken;
    int n_ticks;
    int n_settings;
    int stall_left;
    bit quiet;

    always #6 clk = ~clk;

    keypad_display_scan_entry u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    keypad_display_scan_entry_check u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_accepted   (taken)
    );

    // Result side: stall in random bursts, never once the run is quiet
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Rows for a press on one row: rows above it released, rows below random,
    // since only the highest pulled-low row decides the key.
    function automatic logic [3:0] press_rows(input int row);
        logic [3:0] above;
        logic [3:0] below;
        above = 4'hF << (row + 1);
        below = 4'($urandom) & ~(4'hF << row);
        return above | below;
    endfunction

    // Partly real presses on the scanned column, the rest idle or raw noise;
    // favor key A on its column so the display gets cleared now and then.
    function automatic logic [3:0] random_rows(input int col);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3) return ROWS_NONE;
        if (pick < 6) return 4'($urandom);
        if (col == CLEAR_COL && $urandom_range(0, 2) == 0) return press_rows(0);
        return press_rows($urandom_range(0, 3));
    endfunction

    // Offer one tick request and hold it until taken; valid stays high on return
    task automatic push_tick(input logic [3:0] rows);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, rows};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_ticks++;
    endtask

    task automatic run_random(input int count);
        repeat (count) push_tick(random_rows(n_ticks % NUM_DIGITS));
    endtask

    // Advance with released rows until the next tick lands on the given column
    task automatic pad_to(input int col);
        while (n_ticks % NUM_DIGITS != col) push_tick(ROWS_NONE);
    endtask

    // Let a running hold-off run out so the next setting starts clean
    task automatic drain_holdoff(input int ticks);
        repeat (ticks) push_tick(ROWS_NONE);
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_holdoff(input logic [15:0] ticks);
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    initial begin
        int holds [6];
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        rst_n     <= 1'b0;
        quiet      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset hold-off: key 1 on digit one is taken, then keys are only seen
        push_tick(press_rows(0));
        run_random(30);
        drain_holdoff(HOLDOFF_RESET + 1);

        // Zero hold-off: start from a cleared display on digit one
        wait_drained();
        write_holdoff(16'd0);
        pad_to(CLEAR_COL);
        push_tick(press_rows(0));
        for (int i = 0; i < 20; i++) push_tick(DIRECTED_ROWS[i]);

        // Random phases over a spread of hold-off lengths
        holds[0] = 1;
        holds[1] = 0;
        holds[2] = 2;
        holds[3] = 3;
        holds[4] = $urandom_range(4, 15);
        holds[5] = $urandom_range(20, 60);
        foreach (holds[p]) begin
            wait_drained();
            write_holdoff(16'(holds[p]));
            run_random(RANDOM_PHASE_TICKS);
            drain_holdoff(holds[p] + 1);
        end

        // Longest hold-off, no idling: one clear is taken, everything after ignored
        wait_drained();
        quiet = 1'b1;
        write_holdoff(16'hFFFF);
        pad_to(CLEAR_COL);
        push_tick(press_rows(0));
        run_random(LAST_PHASE_TICKS);

        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);

        $display("Scan ticks sent %0d, results checked %0d, keys taken %0d,",
                 n_ticks, checked, taken);
        $display("over %0d hold-off settings from zero to the maximum; mismatches %0d",
                 n_settings + 1, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire
